### rtl/mprc_pkg.sv
// ----------------------------------------------------------------------------
// mprc_pkg
// Shared types, widths and constants for the multi-press relay controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mprc_pkg;

	// Elapsed-time counters and the release counter.
	localparam int TIMER_BITS = 16;
	localparam int COUNT_BITS = 8;

	// Register widths.
	localparam int DEB_W    = 10;
	localparam int MS_W     = 16;
	localparam int TARGET_W = 8;

	// Compare widths wide enough for both a counter and a register.
	localparam int CMP_W  = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;
	localparam int CCMP_W = (COUNT_BITS > TARGET_W) ? COUNT_BITS : TARGET_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE  = 3'd0,
		REG_RELAY_ON  = 3'd1,
		REG_TARGET    = 3'd2,
		REG_WINDOW    = 3'd3,
		REG_ENABLE    = 3'd4,
		REG_HOLD      = 3'd5
	} reg_idx_t;

	// Register reset values, also loaded when a write would give a useless value.
	localparam logic [DEB_W-1:0]    DEBOUNCE_RST = 10'd50;
	localparam logic [MS_W-1:0]     RELAY_ON_RST = 16'd4000;
	localparam logic [TARGET_W-1:0] TARGET_RST   = 8'd5;
	localparam logic [MS_W-1:0]     WINDOW_RST   = 16'd4000;
	localparam logic [MS_W-1:0]     HOLD_RST     = 16'd8000;

	// Remaining hold time thresholds for the blink stages.
	localparam logic [MS_W-1:0] LEFT_FAST   = 16'd2000;
	localparam logic [MS_W-1:0] LEFT_MEDIUM = 16'd4000;
	localparam logic [MS_W-1:0] LEFT_SLOW   = 16'd6000;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_ON   = 2'd1,
		OP_OFF  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		BLINK_NONE   = 2'd0,
		BLINK_SLOW   = 2'd1,
		BLINK_MEDIUM = 2'd2,
		BLINK_FAST   = 2'd3
	} blink_t;

	typedef struct packed {
		logic [DEB_W-1:0]    debounce_ms;
		logic [MS_W-1:0]     relay_on_ms;
		logic [TARGET_W-1:0] press_target;
		logic [MS_W-1:0]     press_window_ms;
		logic                system_enabled;
		logic [MS_W-1:0]     reset_hold_ms;
	} cfg_t;

	// Packed with the last field in the lowest bits, so the struct is tdata as is.
	typedef struct packed {
		logic [7:0] presses_so_far;
		logic       relay_expired;
		logic       window_expired;
		logic       opened_by_presses;
		logic       press_notice;
		logic       reset_fire;
		blink_t     blink_stage;
		logic       relay_state;
	} result_t;

endpackage

`default_nettype wire

### rtl/mprc_cfg.sv
// ----------------------------------------------------------------------------
// mprc_cfg
// Configuration register file; replaces out-of-range writes by defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module mprc_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [mprc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [mprc_pkg::CFG_DATA_W-1:0] wr_data,
	output mprc_pkg::cfg_t                       cfg
);
	import mprc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= DEBOUNCE_RST;
			cfg_q.relay_on_ms     <= RELAY_ON_RST;
			cfg_q.press_target    <= TARGET_RST;
			cfg_q.press_window_ms <= WINDOW_RST;
			cfg_q.system_enabled  <= 1'b1;
			cfg_q.reset_hold_ms   <= HOLD_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_DEBOUNCE: begin
					cfg_q.debounce_ms <= wr_data[DEB_W-1:0];
				end
				REG_RELAY_ON: begin
					cfg_q.relay_on_ms <= (wr_data == '0) ? RELAY_ON_RST : wr_data;
				end
				REG_TARGET: begin
					cfg_q.press_target <= (wr_data[TARGET_W-1:1] == '0) ? TARGET_RST
						: wr_data[TARGET_W-1:0];
				end
				REG_WINDOW: begin
					cfg_q.press_window_ms <= (wr_data == '0) ? WINDOW_RST : wr_data;
				end
				REG_ENABLE: begin
					cfg_q.system_enabled <= wr_data[0];
				end
				REG_HOLD: begin
					cfg_q.reset_hold_ms <= wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### rtl/mprc_core.sv
// ----------------------------------------------------------------------------
// mprc_core
// Controller state and the update it makes for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module mprc_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire mprc_pkg::cfg_t cfg,
	input  wire logic    step,
	input  wire mprc_pkg::op_t  op,
	input  wire logic    button,
	output mprc_pkg::result_t res
);
	import mprc_pkg::*;

	logic                  stable_q,   stable_d;
	logic [DEB_W-1:0]      quiet_q,    quiet_d;
	logic                  hold_act_q, hold_act_d;
	logic [TIMER_BITS-1:0] hold_tmr_q, hold_tmr_d;
	logic                  relay_q,    relay_d;
	logic                  rly_act_q,  rly_act_d;
	logic [TIMER_BITS-1:0] rly_tmr_q,  rly_tmr_d;
	logic                  win_act_q,  win_act_d;
	logic [TIMER_BITS-1:0] win_tmr_q,  win_tmr_d;
	logic [COUNT_BITS-1:0] count_q,    count_d;

	logic fire, notice, opened, wexp, rexp;
	logic [CMP_W-1:0]  left;
	logic [CCMP_W-1:0] count_ext;

	function automatic logic [TIMER_BITS-1:0] tinc(input logic [TIMER_BITS-1:0] v);
		return (&v) ? v : v + TIMER_BITS'(1);
	endfunction

	function automatic logic tge(input logic [TIMER_BITS-1:0] t, input logic [MS_W-1:0] c);
		return CMP_W'(t) >= CMP_W'(c);
	endfunction

	always_comb begin
		stable_d   = stable_q;
		quiet_d    = quiet_q;
		hold_act_d = hold_act_q;
		hold_tmr_d = hold_tmr_q;
		relay_d    = relay_q;
		rly_act_d  = rly_act_q;
		rly_tmr_d  = rly_tmr_q;
		win_act_d  = win_act_q;
		win_tmr_d  = win_tmr_q;
		count_d    = count_q;
		fire   = 1'b0;
		notice = 1'b0;
		opened = 1'b0;
		wexp   = 1'b0;
		rexp   = 1'b0;

		if (step) begin
			unique case (op)
				OP_ON, OP_OFF: begin
					if (relay_q != (op == OP_ON)) begin
						win_act_d = 1'b0;
						win_tmr_d = '0;
						count_d   = '0;
						relay_d   = (op == OP_ON);
						rly_tmr_d = '0;
						rly_act_d = (op == OP_ON);
					end
				end
				OP_TICK: begin
					if (hold_act_q) hold_tmr_d = tinc(hold_tmr_q);
					if (rly_act_q) rly_tmr_d = tinc(rly_tmr_q);
					if (win_act_q) win_tmr_d = tinc(win_tmr_q);
					quiet_d = (&quiet_q) ? quiet_q : quiet_q + DEB_W'(1);

					if (hold_act_q && tge(hold_tmr_d, cfg.reset_hold_ms)) begin
						hold_act_d = 1'b0;
						hold_tmr_d = '0;
						fire       = 1'b1;
					end
					if (rly_act_q && tge(rly_tmr_d, cfg.relay_on_ms)) begin
						rly_act_d = 1'b0;
						rly_tmr_d = '0;
						relay_d   = 1'b0;
						rexp      = 1'b1;
					end

					// Any raw change restarts the quiet window, accepted or not.
					if (button != stable_q) begin
						if (quiet_d > cfg.debounce_ms) begin
							stable_d   = button;
							hold_act_d = button;
							hold_tmr_d = '0;
							if (button) begin
								notice = !win_act_d;
							end else if (cfg.system_enabled) begin
								if (!win_act_d) begin
									win_act_d = 1'b1;
									win_tmr_d = '0;
									count_d   = '0;
								end
								count_d = (&count_d) ? count_d : count_d + COUNT_BITS'(1);
								if (CCMP_W'(count_d) >= CCMP_W'(cfg.press_target)) begin
									if (!relay_d) begin
										relay_d   = 1'b1;
										rly_tmr_d = '0;
										rly_act_d = 1'b1;
									end
									win_act_d = 1'b0;
									win_tmr_d = '0;
									count_d   = '0;
									opened    = 1'b1;
								end
							end
						end
						quiet_d = '0;
					end

					if (cfg.system_enabled && win_act_d &&
							tge(win_tmr_d, cfg.press_window_ms)) begin
						win_act_d = 1'b0;
						win_tmr_d = '0;
						count_d   = '0;
						wexp      = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q   <= 1'b0;
			quiet_q    <= '1;
			hold_act_q <= 1'b0;
			hold_tmr_q <= '0;
			relay_q    <= 1'b0;
			rly_act_q  <= 1'b0;
			rly_tmr_q  <= '0;
			win_act_q  <= 1'b0;
			win_tmr_q  <= '0;
			count_q    <= '0;
		end else begin
			stable_q   <= stable_d;
			quiet_q    <= quiet_d;
			hold_act_q <= hold_act_d;
			hold_tmr_q <= hold_tmr_d;
			relay_q    <= relay_d;
			rly_act_q  <= rly_act_d;
			rly_tmr_q  <= rly_tmr_d;
			win_act_q  <= win_act_d;
			win_tmr_q  <= win_tmr_d;
			count_q    <= count_d;
		end
	end

	// The blink stage reflects the state after this item.
	assign left      = CMP_W'(cfg.reset_hold_ms) - CMP_W'(hold_tmr_d);
	assign count_ext = CCMP_W'(count_d);

	always_comb begin
		res.relay_state       = relay_d;
		res.reset_fire        = fire;
		res.press_notice      = notice;
		res.opened_by_presses = opened;
		res.window_expired    = wexp;
		res.relay_expired     = rexp;
		res.presses_so_far    = count_ext[7:0];
		priority if (!hold_act_d || tge(hold_tmr_d, cfg.reset_hold_ms)) begin
			res.blink_stage = BLINK_NONE;
		end else if (left < CMP_W'(LEFT_FAST)) begin
			res.blink_stage = BLINK_FAST;
		end else if (left < CMP_W'(LEFT_MEDIUM)) begin
			res.blink_stage = BLINK_MEDIUM;
		end else if (left < CMP_W'(LEFT_SLOW)) begin
			res.blink_stage = BLINK_SLOW;
		end else begin
			res.blink_stage = BLINK_NONE;
		end
	end

endmodule

`default_nettype wire

### rtl/multi_press_relay_controller_unit.sv
// ----------------------------------------------------------------------------
// multi_press_relay_controller_unit
// Debounced multi-press relay controller with long-hold reset detection.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis channel: tuser carries the operation
// (millisecond tick, remote on, remote off) and tdata bit 0 the raw button
// sample used on a tick. Each input item produces exactly one status item on
// the m_axis channel with the relay state, blink stage and event pulses.
// An accepted item is held in the input register; once the output register
// is free or being read, the controller state is updated and the status is
// captured in the output register. One item per cycle is taken while
// m_axis_tready stays high; the input register acts as a skid stage, so
// one more item is accepted while a result waits for the receiver. When
// m_axis_tready stays low, both registers fill and s_axis_tready drops until
// the result is taken. Configuration writes on the cfg channel are always
// accepted and take effect on the next item; write them only while no item
// is in flight.
// Reset loads the default register values, releases the relay, clears the
// timers and the press counter and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_press_relay_controller_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [0] button_level, [7:1] zero
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] relay_state, [2:1] blink_stage, [3] reset_fire, [4] press_notice,
	// [5] opened_by_presses, [6] window_expired, [7] relay_expired,
	// [15:8] presses_so_far
	output logic [15:0]      m_axis_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import mprc_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_q;
	logic    out_vld_q;
	logic    vld_s1;
	op_t     op_s1;
	logic    btn_s1;
	logic    advance;

	assign cfg_ready = 1'b1;

	mprc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance       = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1  <= op_t'(s_axis_tuser);
			btn_s1 <= s_axis_tdata[0];
		end
	end

	mprc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.op     (op_s1),
		.button (btn_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = res_q;

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-press relay controller unit. Ticks with
// button samples and remote commands go in on the input stream. A status
// board predicts one status item per accepted item and compares it, field by
// field, with what leaves the output stream. Press bursts, bounces, noise,
// remote commands and holds up to the reset pulse run under several register
// settings, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mprc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int STALL_CYCLES = 64;

	class relay_status_board;
		logic [DEB_W-1:0]      deb_ms;
		logic [MS_W-1:0]       relay_ms;
		logic [TARGET_W-1:0]   target;
		logic [MS_W-1:0]       window_ms;
		logic                  enabled;
		logic [MS_W-1:0]       hold_ms;

		logic                  btn_stable;
		logic [DEB_W-1:0]      quiet;
		logic                  holding;
		logic [TIMER_BITS-1:0] hold_t;
		logic                  relay_on;
		logic                  relay_run;
		logic [TIMER_BITS-1:0] relay_t;
		logic                  win_open;
		logic [TIMER_BITS-1:0] win_t;
		logic [COUNT_BITS-1:0] presses;

		result_t status_queue[$];
		int mismatches;

		function new();
			deb_ms = DEBOUNCE_RST;
			relay_ms = RELAY_ON_RST;
			target = TARGET_RST;
			window_ms = WINDOW_RST;
			enabled = 1'b1;
			hold_ms = HOLD_RST;
			btn_stable = 1'b0;
			quiet = '1;
			holding = 1'b0;
			hold_t = '0;
			relay_on = 1'b0;
			relay_run = 1'b0;
			relay_t = '0;
			win_open = 1'b0;
			win_t = '0;
			presses = '0;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [15:0] val);
			case (idx)
			REG_DEBOUNCE: deb_ms = val[DEB_W-1:0];
			REG_RELAY_ON: relay_ms = (val == '0) ? RELAY_ON_RST : val;
			REG_TARGET:   target = (val[7:0] < 8'd2) ? TARGET_RST : val[7:0];
			REG_WINDOW:   window_ms = (val == '0) ? WINDOW_RST : val;
			REG_ENABLE:   enabled = val[0];
			REG_HOLD:     hold_ms = val;
			default: ;
			endcase
		endfunction

		function void clear_window();
			win_open = 1'b0;
			win_t = '0;
			presses = '0;
		endfunction

		function void switch_relay(logic on);
			if (relay_on == on)
				return;
			clear_window();
			relay_on = on;
			relay_t = '0;
			relay_run = on;
		endfunction

		function blink_t blink_now();
			logic [CMP_W-1:0] left;
			if (!holding || hold_t >= hold_ms)
				return BLINK_NONE;
			left = hold_ms - hold_t;
			if (left < LEFT_FAST)
				return BLINK_FAST;
			if (left < LEFT_MEDIUM)
				return BLINK_MEDIUM;
			if (left < LEFT_SLOW)
				return BLINK_SLOW;
			return BLINK_NONE;
		endfunction

		function result_t predict_status(logic [1:0] op, logic raw);
			result_t r;
			logic bounce;
			r = '0;
			case (op)
			OP_ON:  switch_relay(1'b1);
			OP_OFF: switch_relay(1'b0);
			OP_TICK: begin
				// Timers advance first and saturate at all ones.
				if (holding && hold_t != '1)
					hold_t = hold_t + TIMER_BITS'(1);
				if (relay_run && relay_t != '1)
					relay_t = relay_t + TIMER_BITS'(1);
				if (win_open && win_t != '1)
					win_t = win_t + TIMER_BITS'(1);
				if (quiet != '1)
					quiet = quiet + DEB_W'(1);
				if (holding && hold_t >= hold_ms) begin
					holding = 1'b0;
					hold_t = '0;
					r.reset_fire = 1'b1;
				end
				if (relay_run && relay_t >= relay_ms) begin
					relay_run = 1'b0;
					relay_t = '0;
					relay_on = 1'b0;
					r.relay_expired = 1'b1;
				end
				if (raw != btn_stable) begin
					// Any raw change restarts the quiet window, accepted or not.
					bounce = (quiet <= deb_ms);
					quiet = '0;
					if (!bounce) begin
						btn_stable = raw;
						holding = raw;
						hold_t = '0;
						if (raw) begin
							if (!win_open)
								r.press_notice = 1'b1;
						end else if (enabled) begin
							if (!win_open) begin
								win_open = 1'b1;
								win_t = '0;
								presses = '0;
							end
							if (presses != '1)
								presses = presses + COUNT_BITS'(1);
							if (presses >= target) begin
								switch_relay(1'b1);
								clear_window();
								r.opened_by_presses = 1'b1;
							end
						end
					end
				end
				if (enabled && win_open && win_t >= window_ms) begin
					clear_window();
					r.window_expired = 1'b1;
				end
			end
			default: ;
			endcase
			r.relay_state = relay_on;
			r.blink_stage = blink_now();
			r.presses_so_far = 8'(presses);
			return r;
		endfunction

		function void note_item(logic [1:0] op, logic raw);
			status_queue.push_back(predict_status(op, raw));
		endfunction

		task report(string field, int got, int want);
			$display("status mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
			mismatches++;
		endtask

		task check_status(logic [15:0] data);
			result_t got;
			result_t want;
			got = result_t'(data);
			if (status_queue.size() == 0) begin
				report("unexpected status item", int'(data), 0);
				return;
			end
			want = status_queue.pop_front();
			if (got.relay_state != want.relay_state)
				report("relay_state", int'(got.relay_state), int'(want.relay_state));
			if (got.blink_stage != want.blink_stage)
				report("blink_stage", int'(got.blink_stage), int'(want.blink_stage));
			if (got.reset_fire != want.reset_fire)
				report("reset_fire", int'(got.reset_fire), int'(want.reset_fire));
			if (got.press_notice != want.press_notice)
				report("press_notice", int'(got.press_notice), int'(want.press_notice));
			if (got.opened_by_presses != want.opened_by_presses)
				report("opened_by_presses", int'(got.opened_by_presses),
					int'(want.opened_by_presses));
			if (got.window_expired != want.window_expired)
				report("window_expired", int'(got.window_expired), int'(want.window_expired));
			if (got.relay_expired != want.relay_expired)
				report("relay_expired", int'(got.relay_expired), int'(want.relay_expired));
			if (got.presses_so_far != want.presses_so_far)
				report("presses_so_far", int'(got.presses_so_far), int'(want.presses_so_far));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	relay_status_board board = new();
	int src_idle = 17;
	int snk_idle = 81;
	int items_sent = 0;
	int cycle_count = 0;
	bit pressure_req = 1'b0;

	multi_press_relay_controller_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver side: random back-pressure, plus one long hold-off on request.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_req) begin
				pressure_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (STALL_CYCLES) @(negedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= snk_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_status(m_axis_tdata);
	end

	task automatic send_item(logic [1:0] op, logic level);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, level};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		board.note_item(op, level);
		items_sent++;
	endtask

	task automatic send_ticks(logic level, int n);
		repeat (n) send_item(OP_TICK, level);
	endtask

	task automatic park_input();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		park_input();
		while (board.status_queue.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_setting(int k);
		logic [15:0] deb, rly, tgt, win, en, hold;
		case (k)
		0: begin deb = 2; rly = 30; tgt = 3; win = 80; en = 1; hold = 6000; end
		1: begin deb = 0; rly = 1; tgt = 2; win = 1; en = 1; hold = 6000; end
		3: begin deb = 1023; rly = 65535; tgt = 255; win = 65535; en = 1; hold = 65535; end
		// Zero and one load the defaults for the guarded registers.
		4: begin deb = 1; rly = 0; tgt = 1; win = 0; en = 0; hold = 7000; end
		5: begin deb = 3; rly = 20; tgt = 0; win = 200; en = 1; hold = 6500; end
		6: begin
			deb = 16'($urandom_range(0, 5));
			rly = 16'($urandom_range(5, 100));
			tgt = 2;
			win = 16'($urandom_range(20, 100));
			en = 16'($urandom_range(1));
			hold = 16'($urandom_range(6000, 65535));
		end
		8: begin deb = 0; rly = 15; tgt = 4; win = 60; en = 1; hold = 6000; end
		default: begin
			deb = 16'($urandom_range(0, 3));
			rly = 16'($urandom_range(10, 60));
			tgt = 16'($urandom_range(2, 4));
			win = 16'($urandom_range(40, 150));
			en = 1;
			hold = 6000;
		end
		endcase
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_RELAY_ON, rly);
		write_reg(REG_TARGET, tgt);
		write_reg(REG_WINDOW, win);
		write_reg(REG_ENABLE, en);
		write_reg(REG_HOLD, hold);
	endtask

	// One press and release; a length of exactly d ticks falls inside the
	// quiet window and is rejected, one more is accepted.
	task automatic press_once(int d);
		if (d > 0 && $urandom_range(9) == 0) begin
			send_ticks(1'b1, $urandom_range(1, d));
			send_item(OP_TICK, 1'b0);
		end
		send_ticks(1'b1, d + $urandom_range(0, 4));
		send_ticks(1'b0, d + $urandom_range(0, 4));
	endtask

	task automatic run_random(int n);
		int stop_at, d, kind, hi;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			d = (board.deb_ms > 10'd8) ? 8 : int'(board.deb_ms);
			kind = $urandom_range(99);
			if (kind < 60) begin
				hi = (board.target > 8'd5) ? 6 : int'(board.target) + 1;
				repeat ($urandom_range(1, hi)) press_once(d);
			end else if (kind < 72) begin
				case ($urandom_range(3))
				0: send_item(OP_ON, 1'($urandom_range(1)));
				1: send_item(OP_OFF, 1'($urandom_range(1)));
				2: send_item(OP_UNUSED, 1'($urandom_range(1)));
				default: begin
					send_item(OP_ON, 1'b0);
					send_item(OP_ON, 1'b1);
				end
				endcase
			end else if (kind < 85) begin
				// Quiet stretch so that windows and relay timers run out.
				send_ticks(1'b0, $urandom_range(1, 120));
			end else begin
				repeat ($urandom_range(4, 30)) send_item(OP_TICK, 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_TICK;
		cfg_valid = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed items under the reset register values.
		send_item(OP_UNUSED, 1'b1);
		send_item(OP_OFF, 1'b0);
		send_item(OP_ON, 1'b1);
		send_item(OP_ON, 1'b0);
		send_item(OP_OFF, 1'b1);
		send_item(OP_TICK, 1'b1);
		send_item(OP_TICK, 1'b0);
		send_ticks(1'b1, 3);
		send_item(OP_UNUSED, 1'b0);
		send_item(OP_ON, 1'b0);
		send_item(OP_OFF, 1'b0);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin src_idle = 17; snk_idle = 81; end
			1: begin src_idle = 81; snk_idle = 17; end
			default: begin src_idle = 0; snk_idle = 0; end
			endcase
			for (int s = 0; s < 3; s++) begin
				apply_setting(phase * 3 + s);
				if (phase == 2 && s == 0)
					pressure_req = 1'b1;
				run_random(200);
			end
		end

		// Short hold times bring the medium and fast blink stages and the
		// reset pulse within a few dozen ticks.
		write_reg(REG_HOLD, 16'd3000);
		send_ticks(1'b0, 4);
		send_ticks(1'b1, 30);
		send_ticks(1'b0, 8);
		write_reg(REG_HOLD, 16'd40);
		send_ticks(1'b1, 60);
		send_ticks(1'b0, 8);

		park_input();
		while (board.status_queue.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

### filelist.f
rtl/mprc_pkg.sv
rtl/mprc_cfg.sv
rtl/mprc_core.sv
rtl/multi_press_relay_controller_unit.sv
verif/tb_top.sv
